// ----- hdl/rdpbb_pkg.sv -----
// ----------------------------------------------------------------------------
// rdpbb_pkg: shared types and constants of the red-dominant bounding box
// Field widths, running-state limits and the structs passed between the top
// level and the box tracker.
// ----------------------------------------------------------------------------
package rdpbb_pkg;

   localparam int CHAN_W = 8;
   localparam int COL_W  = 11;
   localparam int ROW_W  = 10;
   localparam int CNT_W  = 22;

   localparam int X_ALL = 2047;
   localparam int Y_ALL = 1023;

   localparam logic [CHAN_W-1:0] WHITE        = 8'd255;
   localparam logic [CHAN_W-1:0] MARGIN_RESET = 8'd18;
   localparam logic [CNT_W-1:0]  CNT_MAX      = {CNT_W{1'b1}};

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [COL_W-1:0]  col_type;
   typedef logic [ROW_W-1:0]  row_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   // Control of the tracker for the pixel that leaves the input register.
   typedef struct packed {
      logic advance;
      logic is_point;
      logic last;
   } track_ctrl_type;

   // Box of the frame, including the pixel now presented.
   typedef struct packed {
      cnt_type total;
      col_type x_min;
      col_type x_max;
      row_type y_min;
      row_type y_max;
      logic    valid;
   } box_type;

endpackage

// ----- hdl/rdpbb_if.sv -----
// ----------------------------------------------------------------------------
// rdpbb_if: channel interfaces of the red-dominant bounding box
// Pixel request channel, result channel and the margin register write channel,
// each with valid, ready and its payload.
// ----------------------------------------------------------------------------
interface rdpbb_req_if import rdpbb_pkg::*; ();
   logic     valid;
   logic     ready;
   chan_type pix_red;
   chan_type pix_green;
   chan_type pix_blue;
   col_type  col_x;
   row_type  row_y;
   logic     last_pixel;

   modport source (output valid, pix_red, pix_green, pix_blue, col_x, row_y,
                   last_pixel, input ready);
   modport sink   (input valid, pix_red, pix_green, pix_blue, col_x, row_y,
                   last_pixel, output ready);
endinterface

interface rdpbb_rsp_if import rdpbb_pkg::*; ();
   logic     valid;
   logic     ready;
   chan_type out_red;
   chan_type out_green;
   chan_type out_blue;
   logic     is_point;
   logic     frame_done;
   cnt_type  point_total;
   col_type  box_x_min;
   col_type  box_x_max;
   row_type  box_y_min;
   row_type  box_y_max;
   logic     box_valid;

   modport source (output valid, out_red, out_green, out_blue, is_point,
                   frame_done, point_total, box_x_min, box_x_max, box_y_min,
                   box_y_max, box_valid, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, is_point,
                   frame_done, point_total, box_x_min, box_x_max, box_y_min,
                   box_y_max, box_valid, output ready);
endinterface

interface rdpbb_csr_if import rdpbb_pkg::*; ();
   logic     valid;
   logic     ready;
   chan_type data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ----- hdl/rdpbb_box_tracker.sv -----
// ----------------------------------------------------------------------------
// rdpbb_box_tracker: running point count and bounding box of one frame
// Holds the count and the extremes of x and y, presents the box that includes
// the current pixel and clears itself after the last pixel of a frame.
// ----------------------------------------------------------------------------
module rdpbb_box_tracker import rdpbb_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  track_ctrl_type ctrl,
   input  col_type        pix_x,
   input  row_type        pix_y,
   output box_type        box
);

   cnt_type cnt_ff,   cnt_in;
   col_type x_min_ff, x_min_in;
   col_type x_max_ff, x_max_in;
   row_type y_min_ff, y_min_in;
   row_type y_max_ff, y_max_in;

   // State once the current pixel is included.
   always_comb begin
      cnt_in   = cnt_ff;
      x_min_in = x_min_ff;
      x_max_in = x_max_ff;
      y_min_in = y_min_ff;
      y_max_in = y_max_ff;
      if (ctrl.is_point) begin
         if (cnt_ff != CNT_MAX) cnt_in = cnt_ff + 1'b1;
         if (pix_x < x_min_ff)  x_min_in = pix_x;
         if (pix_x > x_max_ff)  x_max_in = pix_x;
         if (pix_y < y_min_ff)  y_min_in = pix_y;
         if (pix_y > y_max_ff)  y_max_in = pix_y;
      end
   end

   always_comb begin
      box.total = cnt_in;
      box.valid = (cnt_in != '0);
      box.x_min = box.valid ? x_min_in : '0;
      box.x_max = box.valid ? x_max_in : '0;
      box.y_min = box.valid ? y_min_in : '0;
      box.y_max = box.valid ? y_max_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset || (ctrl.advance && ctrl.last)) begin
         cnt_ff   <= '0;
         x_min_ff <= COL_W'(X_ALL);
         x_max_ff <= '0;
         y_min_ff <= ROW_W'(Y_ALL);
         y_max_ff <= '0;
      end else if (ctrl.advance) begin
         cnt_ff   <= cnt_in;
         x_min_ff <= x_min_in;
         x_max_ff <= x_max_in;
         y_min_ff <= y_min_in;
         y_max_ff <= y_max_in;
      end
   end

endmodule

// ----- hdl/red_dominant_pixel_bounding_box_core.sv -----
// ----------------------------------------------------------------------------
// red_dominant_pixel_bounding_box_core: red-dominant segmentation with a box
// Marks pixels whose red exceeds green and blue by at least a margin, whitens the
// others and reports the point count and bounding box on the last pixel.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Moves
//  req_chan  in         one pixel request: RGB, x, y, last-pixel mark
//  rsp_chan  out        one result per request: pixel, point flag, frame box
//  csr_chan  in         write of the red margin register (always ready)
//
// Each request passes from acceptance to result through the input register
// and then the result register, and a new request can be taken on
// every clock while results are taken at the same pace.
// The input register accepts a request even while a finished result waits,
// so up to two requests are held during a stall; ready falls only when both
// registers are full and the result is not taken.
// Synchronous reset empties both registers, clears the running box and sets
// the margin to 18.
//
module red_dominant_pixel_bounding_box_core import rdpbb_pkg::*; #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic   clock,
   input  logic   reset,
   rdpbb_req_if.sink   req_chan,
   rdpbb_rsp_if.source rsp_chan,
   rdpbb_csr_if.sink   csr_chan
);

   // Largest coordinate that may enter the box, limited by the field width.
   localparam int X_TOP_INT = (MAX_WIDTH - 1 > X_ALL) ? X_ALL : MAX_WIDTH - 1;
   localparam int Y_TOP_INT = (MAX_HEIGHT - 1 > Y_ALL) ? Y_ALL : MAX_HEIGHT - 1;
   localparam col_type X_TOP = COL_W'(X_TOP_INT);
   localparam row_type Y_TOP = ROW_W'(Y_TOP_INT);

   // The margin register. Writes must arrive only while the block is idle; the block itself does not enforce this.
   chan_type margin_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= MARGIN_RESET;
      end else if (csr_chan.valid) begin
         margin_ff <= csr_chan.data;
      end
   end

   // Input register stage.
   logic     s1_valid_ff;
   chan_type s1_red_ff, s1_green_ff, s1_blue_ff;
   col_type  s1_x_ff;
   row_type  s1_y_ff;
   logic     s1_last_ff;

   logic     rsp_valid_ff;
   logic     s1_advance;

   // The input register moves on whenever the result register is free or
   // its content is taken in this cycle.
   assign s1_advance     = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         s1_red_ff   <= req_chan.pix_red;
         s1_green_ff <= req_chan.pix_green;
         s1_blue_ff  <= req_chan.pix_blue;
         s1_x_ff     <= req_chan.col_x;
         s1_y_ff     <= req_chan.row_y;
         s1_last_ff  <= req_chan.last_pixel;
      end
   end

   // Classification. The sums carry one extra bit so that they never wrap.
   logic [CHAN_W:0] green_sum, blue_sum;
   logic            poi;
   col_type         lim_x;
   row_type         lim_y;

   assign green_sum = {1'b0, margin_ff} + {1'b0, s1_green_ff};
   assign blue_sum  = {1'b0, margin_ff} + {1'b0, s1_blue_ff};
   assign poi       = ({1'b0, s1_red_ff} >= green_sum) &&
                      ({1'b0, s1_red_ff} >= blue_sum);

   // Coordinates beyond the frame are clamped to its last column and row.
   assign lim_x = (s1_x_ff > X_TOP) ? X_TOP : s1_x_ff;
   assign lim_y = (s1_y_ff > Y_TOP) ? Y_TOP : s1_y_ff;

   track_ctrl_type track_ctrl;
   box_type        box;

   assign track_ctrl.advance  = s1_advance;
   assign track_ctrl.is_point = poi;
   assign track_ctrl.last     = s1_last_ff;

   rdpbb_box_tracker u_tracker (
      .clock (clock),
      .reset (reset),
      .ctrl  (track_ctrl),
      .pix_x (lim_x),
      .pix_y (lim_y),
      .box   (box)
   );

   // Result register. The box fields are reported only on the last pixel.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_chan.ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_chan.out_red     <= poi ? s1_red_ff   : WHITE;
         rsp_chan.out_green   <= poi ? s1_green_ff : WHITE;
         rsp_chan.out_blue    <= poi ? s1_blue_ff  : WHITE;
         rsp_chan.is_point    <= poi;
         rsp_chan.frame_done  <= s1_last_ff;
         rsp_chan.point_total <= s1_last_ff ? box.total : '0;
         rsp_chan.box_x_min   <= s1_last_ff ? box.x_min : '0;
         rsp_chan.box_x_max   <= s1_last_ff ? box.x_max : '0;
         rsp_chan.box_y_min   <= s1_last_ff ? box.y_min : '0;
         rsp_chan.box_y_max   <= s1_last_ff ? box.y_max : '0;
         rsp_chan.box_valid   <= s1_last_ff && box.valid;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;

   // Checks on the block's own logic.

   // A result that does not close a frame carries no box.
   a_no_box_mid_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.frame_done) |->
         (rsp_chan.point_total == '0 && !rsp_chan.box_valid))
      else $error("box reported on a pixel that is not the last");

   // A valid box is ordered and goes with a non-zero count.
   a_box_ordered: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.box_valid) |->
         (rsp_chan.box_x_min <= rsp_chan.box_x_max &&
          rsp_chan.box_y_min <= rsp_chan.box_y_max &&
          rsp_chan.point_total != '0))
      else $error("valid box is not ordered or has no points");

   // After the last pixel of a frame moves on, the running count is clear.
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_last_ff) |=> (box.total == '0 || track_ctrl.is_point))
      else $error("running state not cleared after the last pixel");

   // Requests are refused only while both registers are full.
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_chan.ready))
      else $error("request refused with room in the pipeline");

endmodule
